// File: hdl/sed_pkg.sv
// Shared types and constants for the sparse Euclidean distance block.
// No dependencies; imported by sed_isqrt, sed_merge and sparse_euclidean_distance.
package sed_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int INDEX_W     = 16;
  localparam int VALUE_W     = 32;
  localparam int ENTRY_W     = INDEX_W + VALUE_W;
  localparam int SUM_W       = 64;
  localparam int ROOT_W      = SUM_W / 2;
  localparam int STEP_W      = $clog2(ROOT_W);

  typedef enum logic [1:0] {
    MODE_LOAD_X = 2'd0,
    MODE_LOAD_Y = 2'd1,
    MODE_FINISH = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SATURATED = 2'd1,
    STATUS_CAPACITY  = 2'd2,
    STATUS_ORDER     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_SQUARE,
    ST_ACC,
    ST_ROOT,
    ST_OUT
  } state_t;

endpackage

// File: hdl/sed_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module sed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/sed_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on sed_pkg.
module sed_isqrt
  import sed_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [SUM_W-1:0]    rad;
  logic [ROOT_W+1:0]   rem;
  logic [ROOT_W+3:0]   rem_sh;
  logic [ROOT_W+3:0]   trial;
  logic                ge;
  logic [ROOT_W+3:0]   diff;

  assign rem_sh = {rem, rad[SUM_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[SUM_W-3:0], 2'b00};
      if (ge) begin
        rem  <= diff[ROOT_W+1:0];
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[ROOT_W+1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: hdl/sed_merge.sv
// Entry buffers, load checks and the index merge with saturating sum of squares.
// Depends on sed_pkg and sed_ram.
module sed_merge
  import sed_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic                      load_y,
  input  logic [INDEX_W-1:0]        feature_index,
  input  logic signed [VALUE_W-1:0] feature_value,
  input  logic                      start,
  output logic                      finished,
  output logic [SUM_W-1:0]          sum,
  output logic [1:0]                flags,
  output logic                      sat
);

  logic [CNT_W-1:0]   cnt_x, cnt_y;
  logic [INDEX_W-1:0] last_x, last_y;
  logic [CNT_W-1:0]   i, j;
  logic [ENTRY_W-1:0] rd_x, rd_y;
  logic               busy_cmp, busy_sq, busy_acc, busy_fetch;
  logic               we_x, we_y;
  logic               order_bad, full;
  logic [CNT_W-1:0]   cnt_sel;
  logic [INDEX_W-1:0] last_sel;
  logic               has_x, has_y, take_x, take_y;
  logic signed [VALUE_W:0] op_x, op_y, dif;
  logic [VALUE_W-1:0] mag;
  logic [SUM_W-1:0]   sq;
  logic [SUM_W:0]     acc;
  logic               more;

  assign cnt_sel   = load_y ? cnt_y : cnt_x;
  assign last_sel  = load_y ? last_y : last_x;
  assign order_bad = (cnt_sel != '0) && (feature_index <= last_sel);
  assign full      = cnt_sel >= CNT_W'(MAX_ENTRIES);
  assign we_x      = load && !load_y && !order_bad && !full;
  assign we_y      = load && load_y && !order_bad && !full;

  sed_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram_x (
    .clk   (clk),
    .we    (we_x),
    .waddr (cnt_x[ADDR_W-1:0]),
    .wdata ({feature_index, feature_value}),
    .raddr (i[ADDR_W-1:0]),
    .rdata (rd_x)
  );

  sed_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram_y (
    .clk   (clk),
    .we    (we_y),
    .waddr (cnt_y[ADDR_W-1:0]),
    .wdata ({feature_index, feature_value}),
    .raddr (j[ADDR_W-1:0]),
    .rdata (rd_y)
  );

  assign has_x  = i < cnt_x;
  assign has_y  = j < cnt_y;
  assign take_x = has_x && (!has_y || rd_x[ENTRY_W-1 -: INDEX_W] <= rd_y[ENTRY_W-1 -: INDEX_W]);
  assign take_y = has_y && (!has_x || rd_y[ENTRY_W-1 -: INDEX_W] <= rd_x[ENTRY_W-1 -: INDEX_W]);
  assign op_x   = take_x ? {rd_x[VALUE_W-1], rd_x[VALUE_W-1:0]} : '0;
  assign op_y   = take_y ? {rd_y[VALUE_W-1], rd_y[VALUE_W-1:0]} : '0;
  assign dif    = op_x - op_y;
  assign acc    = {1'b0, sum} + {1'b0, sq};
  assign more   = has_x || has_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_x      <= '0;
      cnt_y      <= '0;
      flags      <= '0;
      busy_fetch <= 1'b0;
      busy_cmp   <= 1'b0;
      busy_sq    <= 1'b0;
      busy_acc   <= 1'b0;
      finished   <= 1'b0;
    end else begin
      finished   <= 1'b0;
      busy_cmp   <= busy_fetch;
      busy_sq    <= busy_cmp;
      busy_acc   <= busy_sq;
      busy_fetch <= 1'b0;
      if (load) begin
        if (order_bad) begin
          flags[1] <= 1'b1;
        end else if (full) begin
          flags[0] <= 1'b1;
        end else if (load_y) begin
          cnt_y <= cnt_y + 1'b1;
        end else begin
          cnt_x <= cnt_x + 1'b1;
        end
      end
      if (start) begin
        busy_fetch <= (cnt_x != '0) || (cnt_y != '0);
        finished   <= (cnt_x == '0) && (cnt_y == '0);
      end
      if (busy_acc) begin
        busy_fetch <= more;
        finished   <= !more;
      end
      if (finished) begin
        cnt_x <= '0;
        cnt_y <= '0;
        flags <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !order_bad && !full) begin
      if (load_y) begin
        last_y <= feature_index;
      end else begin
        last_x <= feature_index;
      end
    end
    if (start) begin
      i   <= '0;
      j   <= '0;
      sum <= '0;
      sat <= 1'b0;
    end
    if (busy_cmp) begin
      mag <= dif[VALUE_W] ? VALUE_W'(-dif) : dif[VALUE_W-1:0];
      if (take_x) begin
        i <= i + 1'b1;
      end
      if (take_y) begin
        j <= j + 1'b1;
      end
    end
    if (busy_sq) begin
      sq <= SUM_W'(mag) * SUM_W'(mag);
    end
    if (busy_acc) begin
      if (acc[SUM_W]) begin
        sum <= '1;
        sat <= 1'b1;
      end else begin
        sum <= acc[SUM_W-1:0];
      end
    end
  end

endmodule

// File: hdl/sparse_euclidean_distance.sv
// Sparse Euclidean distance. A load item gives no result. A finish item runs one merge
// step per distinct index, each step being read, compare, square and accumulate, then hands
// the sum off to the root iterations, then done and output load, plus any wait for a result
// still held at the output. Input is held off from a finish until its result is registered;
// loads proceed while a result waits. Reset clears both counts and the error flags, not the
// buffers.
module sparse_euclidean_distance
  import sed_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                mode,
  input  logic [INDEX_W-1:0]        feature_index,
  input  logic signed [VALUE_W-1:0] feature_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ROOT_W-1:0]         distance,
  output logic [1:0]                status
);

  state_t             state, state_next;
  logic               accept, load, finish;
  logic               merged;
  logic [SUM_W-1:0]   sum;
  logic [1:0]         flags;
  logic               sat;
  logic               sq_start;
  logic               sq_done;
  logic [ROOT_W-1:0]  root;
  logic [1:0]         flags_hold;
  logic               out_load;

  assign accept = in_valid && in_ready;
  assign load   = accept && (mode == MODE_LOAD_X || mode == MODE_LOAD_Y);
  assign finish = accept && (mode == MODE_FINISH);

  sed_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .load_y        (mode == MODE_LOAD_Y),
    .feature_index (feature_index),
    .feature_value (feature_value),
    .start         (finish),
    .finished      (merged),
    .sum           (sum),
    .flags         (flags),
    .sat           (sat)
  );

  sed_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sum),
    .done     (sq_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    sq_start   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (finish) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (merged) begin
          sq_start   = 1'b1;
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (merged) begin
      flags_hold <= flags;
    end
    if (out_load) begin
      distance <= root;
      if (flags_hold[1]) begin
        status <= STATUS_ORDER;
      end else if (flags_hold[0]) begin
        status <= STATUS_CAPACITY;
      end else if (sat) begin
        status <= STATUS_SATURATED;
      end else begin
        status <= STATUS_OK;
      end
    end
  end

endmodule
